// ===== sv/gift128_block_cipher_core_assert.svh =====
// Assertion macros shared by the cipher core.
`ifndef GIFT128_BLOCK_CIPHER_CORE_ASSERT_SVH
`define GIFT128_BLOCK_CIPHER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GIFT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GIFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/gift_pkg.sv =====
`default_nettype none
package gift_pkg;

	localparam int ROUND_COUNT = 40;

	typedef enum logic [1:0] {
		CFG_KEY_UPPER = 2'd0,
		CFG_KEY_LOWER = 2'd1
	} cfg_index_t;

	typedef struct packed {
		logic        operation;
		logic [63:0] data_upper;
		logic [63:0] data_lower;
	} req_t;

	typedef struct packed {
		logic [63:0] result_upper;
		logic [63:0] result_lower;
	} rsp_t;

	typedef struct packed {
		logic         decrypt;
		logic [127:0] blk;
	} stage_t;

	typedef logic [ROUND_COUNT-1:0][127:0] masks_t;

	function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
		logic [3:0] y;
		case (x)
			4'h0: y = 4'h1;
			4'h1: y = 4'hA;
			4'h2: y = 4'h4;
			4'h3: y = 4'hC;
			4'h4: y = 4'h6;
			4'h5: y = 4'hF;
			4'h6: y = 4'h3;
			4'h7: y = 4'h9;
			4'h8: y = 4'h2;
			4'h9: y = 4'hD;
			4'hA: y = 4'hB;
			4'hB: y = 4'h7;
			4'hC: y = 4'h5;
			4'hD: y = 4'h0;
			4'hE: y = 4'h8;
			default: y = 4'hE;
		endcase
		return y;
	endfunction

	function automatic logic [3:0] sbox_bwd(input logic [3:0] x);
		logic [3:0] y;
		case (x)
			4'h0: y = 4'hD;
			4'h1: y = 4'h0;
			4'h2: y = 4'h8;
			4'h3: y = 4'h6;
			4'h4: y = 4'h2;
			4'h5: y = 4'hC;
			4'h6: y = 4'h4;
			4'h7: y = 4'hB;
			4'h8: y = 4'hE;
			4'h9: y = 4'h7;
			4'hA: y = 4'h1;
			4'hB: y = 4'hA;
			4'hC: y = 4'h3;
			4'hD: y = 4'h9;
			4'hE: y = 4'hF;
			default: y = 4'h5;
		endcase
		return y;
	endfunction

	function automatic int perm_pos(input int i);
		return 4 * (i / 16) + 32 * ((3 * ((i % 16) / 4) + (i % 4)) % 4) + (i % 4);
	endfunction

	function automatic logic [127:0] sub_fwd(input logic [127:0] x);
		logic [127:0] y;
		for (int n = 0; n < 32; n++) y[4*n +: 4] = sbox_fwd(x[4*n +: 4]);
		return y;
	endfunction

	function automatic logic [127:0] sub_bwd(input logic [127:0] x);
		logic [127:0] y;
		for (int n = 0; n < 32; n++) y[4*n +: 4] = sbox_bwd(x[4*n +: 4]);
		return y;
	endfunction

	function automatic logic [127:0] perm_fwd(input logic [127:0] x);
		logic [127:0] y;
		for (int i = 0; i < 128; i++) y[perm_pos(i)] = x[i];
		return y;
	endfunction

	function automatic logic [127:0] perm_bwd(input logic [127:0] x);
		logic [127:0] y;
		for (int i = 0; i < 128; i++) y[i] = x[perm_pos(i)];
		return y;
	endfunction

	// The schedule is pure rewiring of the key, so each mask is fixed wiring.
	function automatic logic [127:0] round_mask(input logic [127:0] key, input int r);
		logic [15:0] k [8];
		logic [15:0] t6;
		logic [15:0] t7;
		logic [5:0] c;
		logic [31:0] u;
		logic [31:0] v;
		logic [127:0] m;
		for (int i = 0; i < 8; i++) k[i] = key[16*i +: 16];
		c = 6'd0;
		for (int rr = 0; rr < r; rr++) begin
			c = {c[4:0], c[5] ^ c[4] ^ 1'b1};
			t7 = {k[1][1:0], k[1][15:2]};
			t6 = {k[0][11:0], k[0][15:12]};
			for (int i = 0; i < 6; i++) k[i] = k[i+2];
			k[6] = t6;
			k[7] = t7;
		end
		c = {c[4:0], c[5] ^ c[4] ^ 1'b1};
		u = {k[5], k[4]};
		v = {k[1], k[0]};
		m = '0;
		for (int i = 0; i < 32; i++) begin
			m[4*i+2] = u[i];
			m[4*i+1] = v[i];
		end
		for (int i = 0; i < 6; i++) m[4*i+3] = c[i];
		m[127] = ~m[127];
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== sv/gift128_block_cipher_core.sv =====
// GIFT-128 cipher core with one round per pipeline stage: a block is taken in
// every cycle and its result appears on result after passing through every round
// register, marked by a one-cycle done strobe that cannot be held off. busy
// stays low, so start may be held high continuously. The key must only be
// rewritten while no block is in flight.
`default_nettype none
`include "gift128_block_cipher_core_assert.svh"
module gift128_block_cipher_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire gift_pkg::req_t request,
	output logic             done,
	output gift_pkg::rsp_t   result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int RC = gift_pkg::ROUND_COUNT;

	logic [63:0]      key_upper_q;
	logic [63:0]      key_lower_q;
	gift_pkg::masks_t masks;
	logic             vld [RC+1];
	gift_pkg::stage_t pipe [RC+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gift_pkg::CFG_KEY_UPPER: key_upper_q <= cfg_data;
				gift_pkg::CFG_KEY_LOWER: key_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gift_key_sched u_sched (
		.key   ({key_upper_q, key_lower_q}),
		.masks (masks)
	);

	assign vld[0]          = start && !busy;
	assign pipe[0].decrypt = request.operation;
	assign pipe[0].blk     = {request.data_upper, request.data_lower};

	for (genvar j = 0; j < RC; j++) begin : g_round
		gift_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[j]),
			.in_stage  (pipe[j]),
			.enc_mask  (masks[j]),
			.dec_mask  (masks[RC-1-j]),
			.out_valid (vld[j+1]),
			.out_stage (pipe[j+1])
		);
	end

	assign done                = vld[RC];
	assign result.result_upper = pipe[RC].blk[127:64];
	assign result.result_lower = pipe[RC].blk[63:0];

	`GIFT_ASSERT_IMPL(a_never_busy, clk, arst_n, 1'b1, !busy)
	`GIFT_ASSERT_NEXT(a_first_stage, clk, arst_n, start, vld[1])
	`GIFT_ASSERT_IMPL(a_done_tracks, clk, arst_n, done, $past(vld[RC-1]))

endmodule
`default_nettype wire

// ===== sv/gift_key_sched.sv =====
`default_nettype none
module gift_key_sched (
	input  wire logic [127:0]         key,
	output gift_pkg::masks_t          masks
);

	for (genvar r = 0; r < gift_pkg::ROUND_COUNT; r++) begin : g_mask
		assign masks[r] = gift_pkg::round_mask(key, r);
	end

endmodule
`default_nettype wire

// ===== sv/gift_round.sv =====
`default_nettype none
module gift_round (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire gift_pkg::stage_t in_stage,
	input  wire logic [127:0]     enc_mask,
	input  wire logic [127:0]     dec_mask,
	output logic                  out_valid,
	output gift_pkg::stage_t      out_stage
);

	logic             valid_s1;
	gift_pkg::stage_t stage_s1;
	logic [127:0]     enc_blk;
	logic [127:0]     dec_blk;

	assign enc_blk = gift_pkg::perm_fwd(gift_pkg::sub_fwd(in_stage.blk)) ^ enc_mask;
	assign dec_blk = gift_pkg::sub_bwd(gift_pkg::perm_bwd(in_stage.blk ^ dec_mask));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		stage_s1.decrypt <= in_stage.decrypt;
		stage_s1.blk     <= in_stage.decrypt ? dec_blk : enc_blk;
	end

	assign out_valid = valid_s1;
	assign out_stage = stage_s1;

endmodule
`default_nettype wire
